@@ hw/rtl/ism_pkg.sv @@
// Shared types and constants of the integer stack machine.
package ism_pkg;

	localparam int WordW = 32;
	localparam int InW   = 40;

	typedef enum logic [3:0] {
		OP_CONST = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_MAX   = 4'd5,
		OP_MIN   = 4'd6,
		OP_NEG   = 4'd7,
		OP_DUP   = 4'd8,
		OP_SWAP  = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef struct packed {
		logic             start;
		logic [WordW-1:0] dividend;
		logic [WordW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WordW-1:0] quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/ism_ram.sv @@
// Stack word memory: one write port, one read port with registered data.
module ism_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [ism_pkg::WordW-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [ism_pkg::WordW-1:0] rdata
);

	logic [ism_pkg::WordW-1:0] mem [DEPTH];
	logic [ism_pkg::WordW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ism_div.sv @@
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
module ism_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ism_pkg::div_req_t req,
	output ism_pkg::div_rsp_t rsp
);

	localparam int W = ism_pkg::WordW;

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic [4:0]   cnt_q;
	logic         neg_q;
	logic         busy_q;
	logic         done_q;

	logic [W:0]   rem_shift;
	logic [W:0]   diff;

	assign rem_shift = {rem_q, quo_q[W-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operate on magnitudes; the most negative word maps to 2^31 unsigned.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[W-1] ? -req.dividend : req.dividend;
			dvs_q <= req.divisor[W-1] ? -req.divisor : req.divisor;
			neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -quo_q : quo_q;

endmodule

@@ hw/rtl/integer_stack_machine.sv @@
// Integer stack machine: top level with the instruction sequencer.
// Executes one stack instruction per input transfer on a stack of 32-bit
// signed words held in a single-port-write, registered-read memory, with the
// top word mirrored in a register. Each instruction yields one result
// transfer carrying the top word (zero when empty), the depth and a status
// code. One instruction is in flight at a time: CONST, NEG, DUP and the
// two-operand arithmetic pass through the execute and done states, SWAP
// adds a state for its second memory write, and DIV waits in a divide
// state for the divider, which retires one quotient bit per cycle. A finished result waits
// in the output register while the next instruction is taken. The memory
// needs no clearing after reset.
module integer_stack_machine #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [3:0] req_type, [35:4] push_value, [39:36] zero
	input  logic [ism_pkg::InW-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [31:0] top_value, [31+PtrW:32] depth, next 2 bits status, rest zero
	output logic [((34 + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int W    = ism_pkg::WordW;
	localparam int PtrW = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int OutW = ((34 + PtrW + 7) / 8) * 8;
	localparam int PadW = OutW - 34 - PtrW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_WR2,
		S_DONE
	} state_t;

	state_t             state_q;
	ism_pkg::op_t       op_q;
	logic [W-1:0]       val_q;
	logic [PtrW-1:0]    sp_q;
	logic [W-1:0]       top_q;
	logic [W-1:0]       res_q;
	ism_pkg::status_t   st_q;
	logic               out_valid_q;
	logic [OutW-1:0]    out_data_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [W-1:0]       ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [W-1:0]       b_word;

	ism_pkg::div_req_t  div_req;
	ism_pkg::div_rsp_t  div_rsp;

	logic               in_xfer;
	logic               binary;
	ism_pkg::status_t   chk;
	logic [W-1:0]       alu;
	logic [W-1:0]       top_out;

	ism_ram #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(b_word)
	);

	ism_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Always read the word below the top; it is settled by the time it is used.
	assign ram_raddr = AW'(sp_q - PtrW'(2));

	assign binary = op_q inside {[ism_pkg::OP_ADD:ism_pkg::OP_MIN], ism_pkg::OP_SWAP};

	always_comb begin
		chk = ism_pkg::ST_OK;
		if (binary && sp_q < PtrW'(2)) begin
			chk = ism_pkg::ST_UNDER;
		end else if ((op_q == ism_pkg::OP_NEG || op_q == ism_pkg::OP_DUP) && sp_q == '0) begin
			chk = ism_pkg::ST_UNDER;
		end else if ((op_q == ism_pkg::OP_CONST || op_q == ism_pkg::OP_DUP)
				&& sp_q >= PtrW'(STACK_DEPTH)) begin
			chk = ism_pkg::ST_OVER;
		end else if (op_q == ism_pkg::OP_DIV && b_word == '0) begin
			chk = ism_pkg::ST_DIVZ;
		end
	end

	always_comb begin
		case (op_q)
			ism_pkg::OP_ADD: alu = top_q + b_word;
			ism_pkg::OP_SUB: alu = top_q - b_word;
			ism_pkg::OP_MUL: alu = top_q * b_word;
			ism_pkg::OP_MAX: alu = ($signed(top_q) > $signed(b_word)) ? top_q : b_word;
			ism_pkg::OP_MIN: alu = ($signed(top_q) < $signed(b_word)) ? top_q : b_word;
			ism_pkg::OP_NEG: alu = -top_q;
			ism_pkg::OP_CONST: alu = val_q;
			ism_pkg::OP_DUP: alu = top_q;
			ism_pkg::OP_SWAP: alu = b_word;
			default: alu = top_q;
		endcase
	end

	// Memory write port and divider launch.
	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = AW'(sp_q - PtrW'(1));
		ram_wdata        = alu;
		div_req.start    = 1'b0;
		div_req.dividend = top_q;
		div_req.divisor  = b_word;
		case (state_q)
			S_EXEC: begin
				if (chk == ism_pkg::ST_OK) begin
					case (op_q)
						ism_pkg::OP_CONST, ism_pkg::OP_DUP: begin
							ram_we    = 1'b1;
							ram_waddr = AW'(sp_q);
						end
						ism_pkg::OP_NEG, ism_pkg::OP_SWAP: begin
							ram_we    = 1'b1;
						end
						ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL,
						ism_pkg::OP_MAX, ism_pkg::OP_MIN: begin
							ram_we    = 1'b1;
							ram_waddr = AW'(sp_q - PtrW'(2));
						end
						ism_pkg::OP_DIV: begin
							div_req.start = 1'b1;
						end
						default: begin
							ram_we = 1'b0;
						end
					endcase
				end
			end
			S_DIV: begin
				ram_we    = div_rsp.done;
				ram_waddr = AW'(sp_q - PtrW'(2));
				ram_wdata = div_rsp.quotient;
			end
			S_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(sp_q - PtrW'(2));
				ram_wdata = res_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign top_out = (sp_q != '0) ? top_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			top_q       <= '0;
			res_q       <= '0;
			st_q        <= ism_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (m_axis_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					st_q <= chk;
					if (chk == ism_pkg::ST_OK) begin
						case (op_q)
							ism_pkg::OP_CONST, ism_pkg::OP_DUP: begin
								top_q   <= alu;
								sp_q    <= sp_q + PtrW'(1);
								state_q <= S_DONE;
							end
							ism_pkg::OP_NEG: begin
								top_q   <= alu;
								state_q <= S_DONE;
							end
							ism_pkg::OP_SWAP: begin
								top_q   <= alu;
								res_q   <= top_q;
								state_q <= S_WR2;
							end
							ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL,
							ism_pkg::OP_MAX, ism_pkg::OP_MIN: begin
								top_q   <= alu;
								sp_q    <= sp_q - PtrW'(1);
								state_q <= S_DONE;
							end
							ism_pkg::OP_DIV: begin
								state_q <= S_DIV;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						top_q   <= div_rsp.quotient;
						sp_q    <= sp_q - PtrW'(1);
						state_q <= S_DONE;
					end
				end
				S_WR2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {{PadW{1'b0}}, st_q, sp_q, top_out};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= ism_pkg::op_t'(s_axis_tdata[3:0]);
			val_q <= s_axis_tdata[35:4];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
